@@ rtl/rgb_luma_histogram_assert.svh @@
// ----------------------------------------------------------------------------
// RGB and luma histogram - assertion macros
// Shared concurrent assertion forms, each clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LUMA_HISTOGRAM_ASSERT_SVH
`define RGB_LUMA_HISTOGRAM_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define RLH_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define RLH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define RLH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rlh_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB and luma histogram - package
// Field widths, command codes and luma weights of the histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package rlh_pkg;

    localparam int CMD_W   = 2;
    localparam int PIX_W   = 8;
    localparam int CH_W    = 2;
    localparam int NUM_CH  = 4;
    localparam int BIN_COUNT = 256;
    localparam int BIN_AW  = 8;
    localparam int OUT_W   = 32;

    localparam int COUNT_WIDTH_DEF = 32;

    // Depth of the result queue; a power of two so the pointers wrap freely.
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Histogram index of each channel.
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_W-1:0] CH_LUMA  = 2'd3;

    // Luma = (77 R + 150 G + 29 B + 128) >> 8.
    localparam int LUMA_SUM_W = 18;
    localparam logic [LUMA_SUM_W-1:0] LUMA_W_R   = 18'd77;
    localparam logic [LUMA_SUM_W-1:0] LUMA_W_G   = 18'd150;
    localparam logic [LUMA_SUM_W-1:0] LUMA_W_B   = 18'd29;
    localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 18'd128;
    localparam int LUMA_SHIFT = 8;

endpackage

`default_nettype wire

@@ rtl/rlh_ram.sv @@
// ----------------------------------------------------------------------------
// RGB and luma histogram - simple dual-port RAM
// One write port and one read port; the read data is registered and shows
// the old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/rgb_luma_histogram.sv @@
// ----------------------------------------------------------------------------
// RGB and luma histogram - top level
// Four 256-bin histograms (red, green, blue, luma) with running per-channel
// peaks and a pixel total, all counts saturating.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  -----------------  -----------------------------------
//  command   in         i_valid / o_ready  i_cmd, i_red, i_green, i_blue,
//                                          i_channel_sel, i_bin_sel
//  result    out        o_valid / i_ready  o_bin_count, o_channel_max,
//                                          o_pixel_total
//
//  One item is taken per cycle while o_ready is high. Stage 1 issues each
//  item's bin reads to the four bin memories; in stage 2 an add does the
//  read-modify-write and a read pushes its result into the result queue,
//  from which it appears at the outputs. The read-modify-write loop through
//  the memory write port sets the rate. After reset a sweep writes zero to
//  all 256 entries of each memory, one entry per cycle, and o_ready stays
//  low for the whole sweep. A clear item holds o_ready low while it works
//  its way down the pipeline and then for the same sweep.
//  Results wait in a four-entry queue; o_ready drops while the queue and the
//  read items still in the pipeline could fill it.
//
`default_nettype none

`include "rgb_luma_histogram_assert.svh"

module rgb_luma_histogram #(
    parameter int COUNT_WIDTH = rlh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rlh_pkg::CMD_W-1:0]  i_cmd,
    input  logic [rlh_pkg::PIX_W-1:0]  i_red,
    input  logic [rlh_pkg::PIX_W-1:0]  i_green,
    input  logic [rlh_pkg::PIX_W-1:0]  i_blue,
    input  logic [rlh_pkg::CH_W-1:0]   i_channel_sel,
    input  logic [rlh_pkg::BIN_AW-1:0] i_bin_sel,

    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rlh_pkg::OUT_W-1:0]  o_bin_count,
    output logic [rlh_pkg::OUT_W-1:0]  o_channel_max,
    output logic [rlh_pkg::OUT_W-1:0]  o_pixel_total
);

    import rlh_pkg::*;

    localparam int CW      = COUNT_WIDTH;
    localparam int WIDE_W  = (CW > OUT_W) ? CW : OUT_W;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
    localparam int OUTS_W  = $clog2(FIFO_DEPTH + 3);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_SWEEP
    } t_state;

    // Counts wider than the output fields report as all ones once they no
    // longer fit.
    function automatic logic [OUT_W-1:0] f_report(input logic [CW-1:0] v);
        logic [WIDE_W-1:0] ext;
        ext = WIDE_W'(v);
        if (ext > WIDE_W'({OUT_W{1'b1}})) begin
            return '1;
        end
        return ext[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input and bin addresses. Luma is worked out before the first stage,
    // so every stage after it sees four plain bin addresses.
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic [LUMA_SUM_W-1:0] luma_sum;
    logic [BIN_AW-1:0]     in_addr [NUM_CH];

    assign in_acc   = i_valid && o_ready;
    assign luma_sum = LUMA_W_R * LUMA_SUM_W'(i_red) + LUMA_W_G * LUMA_SUM_W'(i_green)
                    + LUMA_W_B * LUMA_SUM_W'(i_blue) + LUMA_ROUND;

    always_comb begin
        if (t_cmd'(i_cmd) == CMD_ADD) begin
            in_addr[CH_RED]   = i_red;
            in_addr[CH_GREEN] = i_green;
            in_addr[CH_BLUE]  = i_blue;
            in_addr[CH_LUMA]  = luma_sum[LUMA_SHIFT +: BIN_AW];
        end else begin
            for (int k = 0; k < NUM_CH; k++) begin
                in_addr[k] = i_bin_sel;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 issues the memory reads; stage 2 gets the read data and, for an
    // add, increments and writes back. The pipeline never stalls.
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic [CH_W-1:0]   r_s1_ch;
    logic [BIN_AW-1:0] r_s1_addr [NUM_CH];

    logic              r_s2_valid;
    t_cmd              r_s2_cmd;
    logic [CH_W-1:0]   r_s2_ch;
    logic [BIN_AW-1:0] r_s2_addr [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            r_s2_valid <= r_s1_valid;
        end
        if (in_acc) begin
            r_s1_cmd  <= t_cmd'(i_cmd);
            r_s1_ch   <= i_channel_sel;
            r_s1_addr <= in_addr;
        end
        r_s2_cmd  <= r_s1_cmd;
        r_s2_ch   <= r_s1_ch;
        r_s2_addr <= r_s1_addr;
    end

    logic s2_add;
    logic s2_read;
    logic s2_clear;

    assign s2_add   = r_s2_valid && (r_s2_cmd == CMD_ADD);
    assign s2_read  = r_s2_valid && (r_s2_cmd == CMD_READ);
    assign s2_clear = r_s2_valid && (r_s2_cmd == CMD_CLEAR);

    // ------------------------------------------------------------------
    // Control: normal running, waiting for a clear to reach stage 2, and
    // the zeroing sweep.
    // ------------------------------------------------------------------
    t_state            r_state;
    t_state            n_state;
    logic [BIN_AW-1:0] r_sweep_cnt;
    logic [BIN_AW-1:0] n_sweep_cnt;
    logic              sweeping;

    assign sweeping = (r_state == ST_SWEEP);

    always_comb begin
        n_state     = r_state;
        n_sweep_cnt = r_sweep_cnt;
        case (r_state)
            ST_RUN: begin
                if (in_acc && (t_cmd'(i_cmd) == CMD_CLEAR)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (s2_clear) begin
                    n_state     = ST_SWEEP;
                    n_sweep_cnt = '0;
                end
            end
            ST_SWEEP: begin
                n_sweep_cnt = r_sweep_cnt + 1'b1;
                if (r_sweep_cnt == BIN_AW'(BIN_COUNT - 1)) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_cnt <= '0;
        end else begin
            r_state     <= n_state;
            r_sweep_cnt <= n_sweep_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Bin memories with write-back forwarding. A bin written by one item
    // is read by the following item before that write lands, so the last
    // written value stands in for the memory data on an address match.
    // ------------------------------------------------------------------
    logic [CW-1:0]     ram_q     [NUM_CH];
    logic [CW-1:0]     fresh     [NUM_CH];
    logic [CW-1:0]     n_cnt     [NUM_CH];
    logic              ram_we;
    logic [BIN_AW-1:0] ram_waddr [NUM_CH];
    logic [CW-1:0]     ram_wdata [NUM_CH];

    logic              r_fwd_valid;
    logic [BIN_AW-1:0] r_fwd_addr [NUM_CH];
    logic [CW-1:0]     r_fwd_data [NUM_CH];

    assign ram_we = sweeping || s2_add;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_bins
        assign fresh[k] = (r_fwd_valid && (r_fwd_addr[k] == r_s2_addr[k]))
                        ? r_fwd_data[k] : ram_q[k];
        assign n_cnt[k] = (&fresh[k]) ? fresh[k] : fresh[k] + CW'(1);

        assign ram_waddr[k] = sweeping ? r_sweep_cnt : r_s2_addr[k];
        assign ram_wdata[k] = sweeping ? '0 : n_cnt[k];

        rlh_ram #(
            .WIDTH (CW),
            .DEPTH (BIN_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (ram_waddr[k]),
            .i_wdata (ram_wdata[k]),
            .i_raddr (r_s1_addr[k]),
            .o_rdata (ram_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= s2_add;
        end
        r_fwd_addr <= r_s2_addr;
        r_fwd_data <= n_cnt;
    end

    // ------------------------------------------------------------------
    // Peaks and pixel total. A peak only ever follows its channel's newly
    // incremented bin, so comparing against that bin is enough.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_peak [NUM_CH];
    logic [CW-1:0] n_peak [NUM_CH];
    logic [CW-1:0] r_pixels;
    logic [CW-1:0] n_pixels;

    always_comb begin
        n_peak   = r_peak;
        n_pixels = r_pixels;
        if (s2_clear) begin
            for (int k = 0; k < NUM_CH; k++) begin
                n_peak[k] = '0;
            end
            n_pixels = '0;
        end else if (s2_add) begin
            for (int k = 0; k < NUM_CH; k++) begin
                if (n_cnt[k] > r_peak[k]) begin
                    n_peak[k] = n_cnt[k];
                end
            end
            if (!(&r_pixels)) begin
                n_pixels = r_pixels + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_peak[k] <= '0;
            end
            r_pixels <= '0;
        end else begin
            r_peak   <= n_peak;
            r_pixels <= n_pixels;
        end
    end

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    logic               fifo_push;
    logic               fifo_pop;
    logic [FIFO_CW-1:0] r_fifo_cnt;
    logic [FIFO_CW-1:0] n_fifo_cnt;
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [OUT_W-1:0]   r_q_bin [FIFO_DEPTH];
    logic [OUT_W-1:0]   r_q_max [FIFO_DEPTH];
    logic [OUT_W-1:0]   r_q_tot [FIFO_DEPTH];
    logic [OUTS_W-1:0]  outstanding;

    assign fifo_push = s2_read;
    assign fifo_pop  = o_valid && i_ready;

    always_comb begin
        n_fifo_cnt = r_fifo_cnt;
        if (fifo_push && !fifo_pop) begin
            n_fifo_cnt = r_fifo_cnt + 1'b1;
        end else if (!fifo_push && fifo_pop) begin
            n_fifo_cnt = r_fifo_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_cnt <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_fifo_cnt <= n_fifo_cnt;
            if (fifo_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (fifo_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (fifo_push) begin
            r_q_bin[r_wr_ptr] <= f_report(fresh[r_s2_ch]);
            r_q_max[r_wr_ptr] <= f_report(r_peak[r_s2_ch]);
            r_q_tot[r_wr_ptr] <= f_report(r_pixels);
        end
    end

    // Read items still in the pipeline each hold a place in the queue.
    assign outstanding = OUTS_W'(r_fifo_cnt)
                       + OUTS_W'(r_s1_valid && (r_s1_cmd == CMD_READ))
                       + OUTS_W'(s2_read);

    assign o_ready       = (r_state == ST_RUN) && (outstanding < OUTS_W'(FIFO_DEPTH));
    assign o_valid       = (r_fifo_cnt != '0);
    assign o_bin_count   = r_q_bin[r_rd_ptr];
    assign o_channel_max = r_q_max[r_rd_ptr];
    assign o_pixel_total = r_q_tot[r_rd_ptr];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RLH_ASSERT_IMPLY(a_no_accept_unless_running, i_clk, i_rst_n,
        r_state != ST_RUN, !o_ready, "item taken while a clear is pending or sweeping")
    `RLH_ASSERT_ALWAYS(a_queue_no_overflow, i_clk, i_rst_n,
        !(fifo_push && !fifo_pop && (r_fifo_cnt == FIFO_CW'(FIFO_DEPTH))),
        "result queue overflow")
    `RLH_ASSERT_NEXT(a_clear_starts_sweep, i_clk, i_rst_n,
        s2_clear, (r_state == ST_SWEEP) && (r_pixels == '0), "clear did not start a sweep")
    `RLH_ASSERT_IMPLY(a_sweep_no_forward, i_clk, i_rst_n,
        sweeping, !r_fwd_valid && !r_s2_valid, "pipeline busy during sweep")

endmodule

`default_nettype wire
